// ===== src/som_pkg.sv =====
// som_pkg: shared types, codes and the sine table function of the segment oscillator mixer
// no dependencies; used by som_ram's users, segment_oscillator_mixer_unit and som_checker
package som_pkg;

  // default sizes
  localparam int DEF_CHANNELS     = 8;
  localparam int DEF_SEGMENTS     = 16;
  localparam int DEF_SINE_ENTRIES = 256;
  localparam int DEF_TIME_BITS    = 24;

  // request codes
  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_TICK   = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_RANGE  = 2'd2,
    ST_UNUSED = 2'd3
  } status_t;

  // wave codes
  localparam logic [2:0] WAVE_SINE     = 3'd0;
  localparam logic [2:0] WAVE_SQUARE   = 3'd1;
  localparam logic [2:0] WAVE_TRIANGLE = 3'd2;
  localparam logic [2:0] WAVE_SAW      = 3'd3;
  localparam logic [2:0] WAVE_NOISE    = 3'd4;

  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] MIX_SCALE = 16'd32767;
  localparam int          MIX_SHIFT = 27;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CHAN,
    S_CHK,
    S_WAVE,
    S_MAC,
    S_SCALE,
    S_ABS,
    S_DIV,
    S_SAT,
    S_DONE
  } seq_state_t;

  // one sine table entry in Q15, built at elaboration (quadrant fold and odd polynomial)
  function automatic logic signed [16:0] sine_entry(input int idx, input int lg);
    longint unsigned a4, q, x, x2, p, r, m, msk;
    logic signed [16:0] res;
    msk = (64'd1 << lg) - 64'd1;
    a4 = 64'(idx) * 64'd4;
    q = (a4 >> lg) & 64'd3;
    x = ((a4 & msk) << 30) >> lg;
    if (q[0]) x = (64'd1 << 30) - x;
    x2 = (x * x) >> 30;
    p = 64'd172272;
    p = 64'd5026990 - ((x2 * p) >> 30);
    p = 64'd85569306 - ((x2 * p) >> 30);
    p = 64'd693598669 - ((x2 * p) >> 30);
    p = 64'd1686629713 - ((x2 * p) >> 30);
    r = (x * p) >> 30;
    m = (r + 64'd16384) >> 15;
    res = 17'(m);
    if (q[1]) res = -res;
    return res;
  endfunction

endpackage

// ===== src/segment_oscillator_mixer_unit.sv =====
// segment_oscillator_mixer_unit: multichannel tone sequencer top level
// depends on som_pkg and som_ram
//
// Usage
//   in_ channel: one request per handshake (append segment, tick, clear); accepted at a
//   rising edge with in_valid high and in_stall low. Every request gives exactly one
//   result on the out_ channel, held steady while out_stall is high.
//   cfg_ port: cfg_we writes num_channels (audible channels and averaging divisor).
//   Append and clear go from accept through S_DONE into the output register; the next
//   request is accepted once the result is there. A tick walks the segment memory
//   one entry per cycle: per audible channel a S_CHAN step, a S_CHK step per segment
//   read up to the covering one, then S_WAVE and S_MAC for the hit; then S_SCALE,
//   S_ABS, the serial divide by num_channels in S_DIV (a quotient of log2 CHANNELS
//   + 22 bits), S_SAT and S_DONE. The segment memory read port bounds the walk.
//   One request is worked at a time; the next is accepted as soon as the previous
//   result has moved into the output register, even while the receiver stalls it.
//   Reset (rst_n low, synchronous) empties all segment lists, zeroes play time, sets
//   num_channels to 1 and the noise generator to its seed. No clearing pass is needed.
module segment_oscillator_mixer_unit #(
  parameter int CHANNELS     = som_pkg::DEF_CHANNELS,
  parameter int SEGMENTS     = som_pkg::DEF_SEGMENTS,
  parameter int SINE_ENTRIES = som_pkg::DEF_SINE_ENTRIES,
  parameter int TIME_BITS    = som_pkg::DEF_TIME_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_req_type,
  input  logic [2:0]         in_channel,
  input  logic [2:0]         in_wave,
  input  logic [31:0]        in_phase_step,
  input  logic signed [15:0] in_amplitude,
  input  logic [23:0]        in_seg_length,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample,
  output logic [1:0]         out_status,
  output logic               out_wrapped,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_wdata
);

  localparam int SLOTS   = CHANNELS * SEGMENTS;
  localparam int AW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CH_IW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH_CW   = $clog2(CHANNELS + 1);
  localparam int CNT_W   = $clog2(SEGMENTS + 1);
  localparam int SINE_LG = $clog2(SINE_ENTRIES);
  localparam int TB      = TIME_BITS;
  localparam int ENT_W   = 3 + 16 + 32 + TB + 24;
  localparam int SUM_W   = 33 + CH_IW;
  localparam int NW      = SUM_W + 16;
  localparam int QW      = NW - som_pkg::MIX_SHIFT;
  localparam int DC_W    = $clog2(QW + 1);
  localparam int CMP_W   = ((TB > 24) ? TB : 24) + 1;
  localparam logic [TB-1:0] TIME_MAX = {TB{1'b1}};

  som_pkg::seq_state_t state_r, state_nxt;

  // control and song state
  logic [CH_CW-1:0]        c_r;
  logic [CNT_W-1:0]        k_r;
  logic [CNT_W-1:0]        cnt_r [CHANNELS];
  logic [TB-1:0]           end_r [CHANNELS];
  logic [TB-1:0]           time_r;
  logic [TB-1:0]           limit_r;
  logic [15:0]             lfsr_r;
  logic [3:0]              nch_r;
  logic                    tick_r;

  // datapath
  logic [31:0]             ph_r;
  logic [2:0]              wsel_r;
  logic signed [15:0]      gain_r;
  logic signed [16:0]      wave_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [NW-1:0]    num_r;
  logic [QW-1:0]           quo_r;
  logic [3:0]              rem_r;
  logic [DC_W-1:0]         dcnt_r;
  logic                    neg_r;

  // pending result and output register
  logic signed [15:0]      res_sample_r;
  logic [1:0]              res_status_r;
  logic                    res_wrapped_r;
  logic                    out_valid_r;
  logic signed [15:0]      out_sample_r;
  logic [1:0]              out_status_r;
  logic                    out_wrapped_r;

  // segment memory ports
  logic                    ram_we, ram_re;
  logic [AW-1:0]           ram_waddr, ram_raddr;
  logic [ENT_W-1:0]        ram_wdata, ram_rdata;

  som_ram #(.WIDTH(ENT_W), .DEPTH(SLOTS)) u_seg_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sine lookup table, constant
  logic signed [16:0] sine_tab [SINE_ENTRIES];
  for (genvar gi = 0; gi < SINE_ENTRIES; gi++) begin : g_sine
    assign sine_tab[gi] = som_pkg::sine_entry(gi, SINE_LG);
  end

  // decoded request fields
  logic [CH_IW-1:0] in_ch_idx;
  logic             in_ch_bad;
  logic             in_list_full;
  logic             accept;
  assign in_ch_idx    = CH_IW'(in_channel);
  assign in_ch_bad    = 32'(in_channel) >= 32'(CHANNELS);
  assign in_list_full = 32'(cnt_r[in_ch_idx]) >= 32'(SEGMENTS);
  assign accept       = in_valid && !in_stall;

  // channel walk helpers
  logic [CH_CW-1:0] na;
  logic [CH_IW-1:0] c_idx;
  logic [CNT_W-1:0] cur_cnt;
  logic             chan_live;
  assign na        = (32'(nch_r) < 32'(CHANNELS)) ? CH_CW'(nch_r) : CH_CW'(CHANNELS);
  assign c_idx     = c_r[CH_IW-1:0];
  assign cur_cnt   = cnt_r[c_idx];
  assign chan_live = c_r < na;

  // read back fields of the entry
  logic [2:0]         rd_wave;
  logic signed [15:0] rd_gain;
  logic [31:0]        rd_ps;
  logic [TB-1:0]      rd_begin;
  logic [23:0]        rd_span;
  logic               rd_cover;
  logic [TB-1:0]      rd_diff;
  logic               k_last;
  assign {rd_wave, rd_gain, rd_ps, rd_begin, rd_span} = ram_rdata;
  assign rd_cover = (time_r >= rd_begin) &&
                    (CMP_W'(time_r) < (CMP_W'(rd_begin) + CMP_W'(rd_span)));
  assign rd_diff  = time_r - rd_begin;
  assign k_last   = (k_r + CNT_W'(1)) >= cur_cnt;

  // gain times wave, full width
  logic signed [32:0] mac_prod;
  assign mac_prod = gain_r * wave_r;

  // divider step
  logic [4:0] div_trial;
  logic       div_ge;
  assign div_trial = {rem_r, quo_r[QW-1]};
  assign div_ge    = div_trial >= {1'b0, nch_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      som_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = (in_req_type == som_pkg::REQ_TICK) ? som_pkg::S_CHAN : som_pkg::S_DONE;
        end
      end
      som_pkg::S_CHAN: begin
        if (!chan_live) begin
          state_nxt = som_pkg::S_SCALE;
        end else if (cur_cnt != '0) begin
          state_nxt = som_pkg::S_CHK;
        end
      end
      som_pkg::S_CHK: begin
        if (rd_cover) begin
          state_nxt = som_pkg::S_WAVE;
        end else if (k_last) begin
          state_nxt = som_pkg::S_CHAN;
        end
      end
      som_pkg::S_WAVE:  state_nxt = som_pkg::S_MAC;
      som_pkg::S_MAC:   state_nxt = som_pkg::S_CHAN;
      som_pkg::S_SCALE: state_nxt = som_pkg::S_ABS;
      som_pkg::S_ABS:   state_nxt = som_pkg::S_DIV;
      som_pkg::S_DIV: begin
        if (dcnt_r == DC_W'(QW - 1)) begin
          state_nxt = som_pkg::S_SAT;
        end
      end
      som_pkg::S_SAT:   state_nxt = som_pkg::S_DONE;
      som_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = som_pkg::S_IDLE;
        end
      end
      default: state_nxt = som_pkg::S_IDLE;
    endcase
  end

  // memory and handshake controls
  always_comb begin
    in_stall  = (state_r != som_pkg::S_IDLE);
    ram_we    = accept && (in_req_type == som_pkg::REQ_APPEND) && !in_ch_bad && !in_list_full;
    ram_waddr = AW'(in_ch_idx) * AW'(SEGMENTS) + AW'(cnt_r[in_ch_idx]);
    ram_wdata = {in_wave, in_amplitude, in_phase_step, end_r[in_ch_idx], in_seg_length};
    ram_re    = 1'b0;
    ram_raddr = AW'(c_idx) * AW'(SEGMENTS);
    if (state_r == som_pkg::S_CHAN) begin
      ram_re = chan_live && (cur_cnt != '0);
    end else if (state_r == som_pkg::S_CHK) begin
      ram_re    = !rd_cover && !k_last;
      ram_raddr = AW'(c_idx) * AW'(SEGMENTS) + AW'(k_r + CNT_W'(1));
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= som_pkg::S_IDLE;
      time_r      <= '0;
      lfsr_r      <= som_pkg::LFSR_SEED;
      nch_r       <= 4'd1;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        cnt_r[i] <= '0;
        end_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        nch_r <= cfg_wdata;
      end
      // append bookkeeping and clear
      if (ram_we) begin
        cnt_r[in_ch_idx] <= cnt_r[in_ch_idx] + CNT_W'(1);
        if ((TB + 1)'(end_r[in_ch_idx]) + (TB + 1)'(in_seg_length) > (TB + 1)'(TIME_MAX)) begin
          end_r[in_ch_idx] <= TIME_MAX;
        end else begin
          end_r[in_ch_idx] <= end_r[in_ch_idx] + TB'(in_seg_length);
        end
      end
      if (accept && in_req_type == som_pkg::REQ_CLEAR) begin
        time_r <= '0;
        for (int i = 0; i < CHANNELS; i++) begin
          cnt_r[i] <= '0;
          end_r[i] <= '0;
        end
      end
      // noise generator advances once per noise hit
      if (state_r == som_pkg::S_WAVE && wsel_r == som_pkg::WAVE_NOISE) begin
        lfsr_r <= {lfsr_r[0] ^ lfsr_r[2] ^ lfsr_r[3] ^ lfsr_r[5], lfsr_r[15:1]};
      end
      // play time advance
      if (state_r == som_pkg::S_SAT) begin
        if ((TB + 1)'(time_r) + (TB + 1)'(1) >= (TB + 1)'(limit_r)) begin
          time_r <= '0;
        end else begin
          time_r <= time_r + TB'(1);
        end
      end
      // output register
      if (state_r == som_pkg::S_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      som_pkg::S_IDLE: begin
        c_r           <= '0;
        k_r           <= '0;
        sum_r         <= '0;
        limit_r       <= '0;
        tick_r        <= 1'b0;
        res_sample_r  <= '0;
        res_status_r  <= som_pkg::ST_OK;
        res_wrapped_r <= 1'b0;
        if (accept) begin
          tick_r <= (in_req_type == som_pkg::REQ_TICK);
          if (in_req_type == som_pkg::REQ_APPEND) begin
            if (in_ch_bad) begin
              res_status_r <= som_pkg::ST_RANGE;
            end else if (in_list_full) begin
              res_status_r <= som_pkg::ST_FULL;
            end
          end
        end
      end
      som_pkg::S_CHAN: begin
        if (chan_live) begin
          if (end_r[c_idx] > limit_r) begin
            limit_r <= end_r[c_idx];
          end
          k_r <= '0;
          if (cur_cnt == '0) begin
            c_r <= c_r + CH_CW'(1);
          end
        end
      end
      som_pkg::S_CHK: begin
        ph_r   <= 32'(rd_ps * 32'(rd_diff));
        wsel_r <= rd_wave;
        gain_r <= rd_gain;
        if (!rd_cover) begin
          if (k_last) begin
            c_r <= c_r + CH_CW'(1);
          end else begin
            k_r <= k_r + CNT_W'(1);
          end
        end
      end
      som_pkg::S_WAVE: begin
        // wave shapes in Q15, triangle peak reaches +32768
        unique case (wsel_r)
          som_pkg::WAVE_SINE:     wave_r <= sine_tab[ph_r[31 -: SINE_LG]];
          som_pkg::WAVE_SQUARE:   wave_r <= ph_r[31] ? -17'sd32768 : 17'sd32768;
          som_pkg::WAVE_TRIANGLE: begin
            wave_r <= $signed(17'((ph_r[31] ? (32'd0 - ph_r) : ph_r) >> 15))
                      - 17'sd32768;
          end
          som_pkg::WAVE_SAW:      wave_r <= 17'(signed'(ph_r[31:16]));
          som_pkg::WAVE_NOISE: begin
            wave_r <= 17'(signed'({lfsr_r[0] ^ lfsr_r[2] ^ lfsr_r[3] ^ lfsr_r[5],
                                   lfsr_r[15:1]}));
          end
          default:                wave_r <= '0;
        endcase
      end
      som_pkg::S_MAC: begin
        sum_r <= sum_r + SUM_W'(mac_prod);
        c_r   <= c_r + CH_CW'(1);
      end
      som_pkg::S_SCALE: begin
        // times 32767 as shift and subtract
        num_r <= (NW'(sum_r) <<< 15) - NW'(sum_r);
      end
      som_pkg::S_ABS: begin
        neg_r  <= num_r[NW-1];
        quo_r  <= QW'((num_r[NW-1] ? (NW'(0) - num_r) : num_r) >>> som_pkg::MIX_SHIFT);
        rem_r  <= '0;
        dcnt_r <= '0;
      end
      som_pkg::S_DIV: begin
        // restoring divide by num_channels, one quotient bit per cycle
        quo_r  <= {quo_r[QW-2:0], div_ge};
        rem_r  <= div_ge ? 4'(div_trial - {1'b0, nch_r}) : div_trial[3:0];
        dcnt_r <= dcnt_r + DC_W'(1);
      end
      som_pkg::S_SAT: begin
        if (nch_r == 4'd0) begin
          res_sample_r <= '0;
        end else if (neg_r) begin
          res_sample_r <= (quo_r > QW'(32768)) ? -16'sd32768 : 16'(QW'(0) - quo_r);
        end else begin
          res_sample_r <= (quo_r > QW'(32767)) ? 16'sd32767 : 16'(quo_r);
        end
        res_wrapped_r <= ((TB + 1)'(time_r) + (TB + 1)'(1) >= (TB + 1)'(limit_r));
      end
      som_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_sample_r  <= tick_r ? res_sample_r : '0;
          out_status_r  <= res_status_r;
          out_wrapped_r <= tick_r && res_wrapped_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid   = out_valid_r;
  assign out_sample  = out_sample_r;
  assign out_status  = out_status_r;
  assign out_wrapped = out_wrapped_r;

endmodule

// ===== src/som_ram.sv =====
// som_ram: generic single write port, single read port memory with registered read
// no dependencies
module som_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/som_checker.sv =====
// som_checker: port level checks of segment_oscillator_mixer_unit, bound to the top level
// depends on som_pkg and segment_oscillator_mixer_unit port names
module som_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_sample,
  input logic [1:0]         out_status,
  input logic               out_wrapped
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample) && $stable(out_status))
    else $error("stalled result changed");

  // only one request is worked at a time
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while busy");

  // status and tick fields never mix
  a_mix: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != som_pkg::ST_OK |-> out_sample == 16'sd0 && !out_wrapped)
    else $error("append status with tick fields");

  // the unused status code never appears
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != som_pkg::ST_UNUSED)
    else $error("bad status code");

  // nothing leaves right after reset
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind segment_oscillator_mixer_unit som_checker u_som_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_sample  (out_sample),
  .out_status  (out_status),
  .out_wrapped (out_wrapped)
);

// ===== sim/tb_segment_oscillator_mixer_unit.sv =====
`timescale 1ns / 100ps
// tb_segment_oscillator_mixer_unit: self-checking bench for the segment oscillator mixer
// depends on som_pkg and segment_oscillator_mixer_unit; a directed table, then random
// phases over several channel counts, checked against a mixer predictor or, in some directed rows, fixed values
module tb_segment_oscillator_mixer_unit;

  localparam int NCH = 8;
  localparam int NSEG = 16;
  localparam int SLOTS = NCH * NSEG;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE = 250;
  localparam int RAND_PER_PHASE = 57;

  typedef struct {
    som_pkg::req_t     kind;
    logic [2:0]        ch;
    logic [2:0]        wave;
    logic [31:0]       step;
    logic signed [15:0] amp;
    logic [23:0]       len;
  } request_t;

  typedef struct {
    logic signed [15:0] sample;
    som_pkg::status_t   status;
    logic               wrapped;
  } mix_out_t;

  typedef struct {
    request_t r;
    int       reps;
    bit       typed;
    mix_out_t want;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] in_req_type = '0;
  logic [2:0] in_channel = '0;
  logic [2:0] in_wave = '0;
  logic [31:0] in_phase_step = '0;
  logic signed [15:0] in_amplitude = '0;
  logic [23:0] in_seg_length = '0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [15:0] out_sample;
  logic [1:0] out_status;
  logic out_wrapped;
  logic cfg_we = 0;
  logic [3:0] cfg_wdata = '0;

  segment_oscillator_mixer_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_channel(in_channel), .in_wave(in_wave),
    .in_phase_step(in_phase_step), .in_amplitude(in_amplitude),
    .in_seg_length(in_seg_length),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_sample(out_sample), .out_status(out_status), .out_wrapped(out_wrapped),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // mixer state mirror
  logic [2:0]         seg_wav [SLOTS];
  logic signed [15:0] seg_gain [SLOTS];
  logic [31:0]        seg_step [SLOTS];
  logic [23:0]        seg_start [SLOTS];
  logic [23:0]        seg_len [SLOTS];
  int unsigned        n_segs [NCH];
  logic [23:0]        ch_end [NCH];
  logic [23:0]        play_pos;
  logic [15:0]        noise_reg;
  logic [3:0]         mix_count;

  mix_out_t pending_samples[$];
  int errors = 0;
  int n_sent = 0, n_checked = 0, n_ticks = 0, n_wraps = 0, n_full = 0;
  int hold_req = 0;
  int cycles = 0;

  // quarter-wave folded odd polynomial, Q30 internally, rounded to Q15
  function automatic int sine_q15(logic [31:0] ph);
    longint unsigned a4, q, x, x2, p, r;
    int m;
    a4 = 64'(ph[31:24]) * 64'd4;
    q = (a4 / 64'd256) & 64'd3;
    x = ((a4 % 64'd256) << 30) / 64'd256;
    if (q[0]) x = (64'd1 << 30) - x;
    x2 = (x * x) >> 30;
    p = 64'd172272;
    p = 64'd5026990 - ((x2 * p) >> 30);
    p = 64'd85569306 - ((x2 * p) >> 30);
    p = 64'd693598669 - ((x2 * p) >> 30);
    p = 64'd1686629713 - ((x2 * p) >> 30);
    r = (x * p) >> 30;
    m = int'((r + 64'd16384) >> 15);
    return q[1] ? -m : m;
  endfunction

  // one oscillator value in Q15; noise steps the lfsr
  function automatic int tone_value(logic [2:0] w, logic [31:0] ph);
    logic [31:0] mag;
    logic fb;
    case (w)
      som_pkg::WAVE_SINE: return sine_q15(ph);
      som_pkg::WAVE_SQUARE: return ph[31] ? -32768 : 32768;
      som_pkg::WAVE_TRIANGLE: begin
        mag = ph[31] ? (32'd0 - ph) : ph;
        return int'(mag >> 15) - 32768;
      end
      som_pkg::WAVE_SAW: return int'($signed(ph[31:16]));
      som_pkg::WAVE_NOISE: begin
        fb = noise_reg[0] ^ noise_reg[2] ^ noise_reg[3] ^ noise_reg[5];
        noise_reg = {fb, noise_reg[15:1]};
        return int'($signed(noise_reg));
      end
      default: return 0;
    endcase
  endfunction

  // expected result of one request, advancing the mirrored state
  function automatic mix_out_t mix_predict(request_t r);
    mix_out_t o;
    int unsigned na, slot;
    longint sum, q, b, t, lim;
    longint unsigned fin;
    logic [31:0] ph;
    o.sample = '0;
    o.status = som_pkg::ST_OK;
    o.wrapped = 1'b0;
    case (r.kind)
      som_pkg::REQ_APPEND: begin
        if (int'(r.ch) >= NCH) begin
          o.status = som_pkg::ST_RANGE;
        end else if (n_segs[r.ch] >= NSEG) begin
          o.status = som_pkg::ST_FULL;
        end else begin
          slot = r.ch * NSEG + n_segs[r.ch];
          seg_wav[slot] = r.wave;
          seg_gain[slot] = r.amp;
          seg_step[slot] = r.step;
          seg_start[slot] = ch_end[r.ch];
          seg_len[slot] = r.len;
          fin = 64'(ch_end[r.ch]) + 64'(r.len);
          ch_end[r.ch] = (fin > 64'hFFFFFF) ? 24'hFFFFFF : fin[23:0];
          n_segs[r.ch]++;
        end
      end
      som_pkg::REQ_TICK: begin
        na = (mix_count < NCH) ? mix_count : NCH;
        sum = 0;
        lim = 0;
        t = longint'(play_pos);
        for (int c = 0; c < na; c++) begin
          for (int k = 0; k < n_segs[c]; k++) begin
            slot = c * NSEG + k;
            b = longint'(seg_start[slot]);
            if (t >= b && t < b + longint'(seg_len[slot])) begin
              ph = 32'(64'(seg_step[slot]) * 64'(t - b));
              sum += longint'(seg_gain[slot]) * longint'(tone_value(seg_wav[slot], ph));
              break;
            end
          end
          if (longint'(ch_end[c]) > lim) lim = longint'(ch_end[c]);
        end
        if (mix_count != 0) begin
          q = (sum * 32767) / (longint'(mix_count) <<< 27);
          if (q > 32767) q = 32767;
          if (q < -32768) q = -32768;
          o.sample = 16'(q);
        end
        if (t + 1 >= lim) begin
          play_pos = '0;
          o.wrapped = 1'b1;
        end else begin
          play_pos = 24'(t + 1);
        end
      end
      som_pkg::REQ_CLEAR: begin
        foreach (n_segs[c]) n_segs[c] = 0;
        foreach (ch_end[c]) ch_end[c] = '0;
        play_pos = '0;
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic request_t mk(som_pkg::req_t k, int ch, int w, logic [31:0] st,
                                  int amp, logic [23:0] len);
    request_t r;
    r.kind = k;
    r.ch = 3'(ch);
    r.wave = 3'(w);
    r.step = st;
    r.amp = 16'(amp);
    r.len = len;
    return r;
  endfunction

  function automatic row_t row(request_t r, int reps, bit typed, int smp,
                               som_pkg::status_t st, bit wr);
    row_t x;
    x.r = r;
    x.reps = reps;
    x.typed = typed;
    x.want.sample = 16'(smp);
    x.want.status = st;
    x.want.wrapped = wr;
    return x;
  endfunction

  // present one request and wait for the handshake; returns at the next falling edge
  task automatic offer(request_t r, bit typed, mix_out_t want);
    mix_out_t exp;
    in_valid = 1'b1;
    in_req_type = r.kind;
    in_channel = r.ch;
    in_wave = r.wave;
    in_phase_step = r.step;
    in_amplitude = r.amp;
    in_seg_length = r.len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    exp = mix_predict(r);
    if (typed) exp = want;
    pending_samples.push_back(exp);
    n_sent++;
    if (r.kind == som_pkg::REQ_TICK) n_ticks++;
    @(negedge clk);
  endtask

  task automatic idle(int n);
    in_valid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // block idle: all results in and the tick engine settled
  task automatic drain();
    in_valid = 1'b0;
    while (pending_samples.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_mix_count(logic [3:0] v);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    mix_count = v;
    @(negedge clk);
  endtask

  // random request, mostly appends of short segments and ticks
  function automatic request_t rand_request();
    request_t r;
    int sel;
    sel = $urandom_range(0, 99);
    r = mk(som_pkg::REQ_TICK, $urandom_range(0, 7), $urandom_range(0, 7), $urandom(),
           int'($urandom() & 32'hFFFF), 24'($urandom_range(0, 12)));
    if ($urandom_range(0, 9) == 0) r.len = 24'($urandom());
    if ($urandom_range(0, 3) == 0) r.step = $urandom_range(0, 1) ? 32'h0 : 32'hFFFFFFFF;
    if (sel < 40) r.kind = som_pkg::REQ_APPEND;
    else if (sel < 93) r.kind = som_pkg::REQ_TICK;
    else if (sel < 97) r.kind = som_pkg::REQ_CLEAR;
    else r.kind = som_pkg::REQ_NONE;
    return r;
  endfunction

  // receiver: long holds on request, otherwise a drifting stall pattern
  initial begin
    int hold_seen, hold_cnt, mode;
    hold_seen = 0;
    hold_cnt = 0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_cnt = 400;
      end
      if (cycles % 64 == 0) mode = $urandom_range(0, 2);
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall = 1'b1;
      end else begin
        case (mode)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(0, 9) < 3);
          default: out_stall = ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    mix_out_t e;
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        $error("result with no request waiting: sample %0d", out_sample);
        errors++;
      end else begin
        e = pending_samples.pop_front();
        n_checked++;
        if (out_wrapped) n_wraps++;
        if (out_status == som_pkg::ST_FULL) n_full++;
        if (out_sample !== e.sample) begin
          $error("sample: expected %0d, got %0d", e.sample, out_sample);
          errors++;
        end
        if (out_status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_status);
          errors++;
        end
        if (out_wrapped !== e.wrapped) begin
          $error("wrapped: expected %0d, got %0d", e.wrapped, out_wrapped);
          errors++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // stimulus
  initial begin
    row_t dir[$];
    logic [3:0] counts[$];
    mix_out_t none_out;
    int burst, n;
    none_out = '{sample: '0, status: som_pkg::ST_OK, wrapped: 1'b0};

    for (int i = 0; i < SLOTS; i++) begin
      seg_wav[i] = '0; seg_gain[i] = '0; seg_step[i] = '0;
      seg_start[i] = '0; seg_len[i] = '0;
    end
    foreach (n_segs[c]) n_segs[c] = 0;
    foreach (ch_end[c]) ch_end[c] = '0;
    play_pos = '0;
    noise_reg = som_pkg::LFSR_SEED;
    mix_count = 4'd1;

    // directed: empty song, unknown request, every wave, extremes, saturation, full list
    dir.push_back(row(mk(som_pkg::REQ_TICK, 0, 0, 0, 0, 0), 1, 1, 0, som_pkg::ST_OK, 1));
    dir.push_back(row(mk(som_pkg::REQ_NONE, 7, 7, '1, -1, '1), 1, 1, 0, som_pkg::ST_OK, 0));
    dir.push_back(row(mk(som_pkg::REQ_APPEND, 0, som_pkg::WAVE_SQUARE, 0, 32767, 2), 1, 1,
                      0, som_pkg::ST_OK, 0));
    dir.push_back(row(mk(som_pkg::REQ_APPEND, 0, som_pkg::WAVE_SQUARE, '1, -32768, 2), 1, 1,
                      0, som_pkg::ST_OK, 0));
    dir.push_back(row(mk(som_pkg::REQ_APPEND, 0, som_pkg::WAVE_SINE, 32'h0400_0000, 4096, 3),
                      1, 0, 0, som_pkg::ST_OK, 0));
    dir.push_back(row(mk(som_pkg::REQ_APPEND, 0, som_pkg::WAVE_TRIANGLE, 32'h3000_0000, 4096,
                         3), 1, 0, 0, som_pkg::ST_OK, 0));
    dir.push_back(row(mk(som_pkg::REQ_APPEND, 0, som_pkg::WAVE_SAW, 32'h5555_5555, -4096, 3),
                      1, 0, 0, som_pkg::ST_OK, 0));
    dir.push_back(row(mk(som_pkg::REQ_APPEND, 0, som_pkg::WAVE_NOISE, 0, 2048, 3), 1, 0,
                      0, som_pkg::ST_OK, 0));
    dir.push_back(row(mk(som_pkg::REQ_APPEND, 0, 5, '1, 32767, 1), 1, 0, 0, som_pkg::ST_OK, 0));
    dir.push_back(row(mk(som_pkg::REQ_APPEND, 0, 6, '1, 32767, 1), 1, 0, 0, som_pkg::ST_OK, 0));
    dir.push_back(row(mk(som_pkg::REQ_APPEND, 0, 7, '1, 32767, 1), 1, 0, 0, som_pkg::ST_OK, 0));
    dir.push_back(row(mk(som_pkg::REQ_APPEND, 0, som_pkg::WAVE_SQUARE, 0, 100, 0), 1, 0,
                      0, som_pkg::ST_OK, 0));
    dir.push_back(row(mk(som_pkg::REQ_TICK, 0, 0, 0, 0, 0), 22, 0, 0, som_pkg::ST_OK, 0));
    dir.push_back(row(mk(som_pkg::REQ_APPEND, 1, som_pkg::WAVE_SINE, 1, 1, '1), 2, 1,
                      0, som_pkg::ST_OK, 0));
    dir.push_back(row(mk(som_pkg::REQ_APPEND, 7, som_pkg::WAVE_SAW, 32'h8000_0000, 32767, 1),
                      16, 0, 0, som_pkg::ST_OK, 0));
    dir.push_back(row(mk(som_pkg::REQ_APPEND, 7, som_pkg::WAVE_SAW, 0, 0, 1), 1, 1,
                      0, som_pkg::ST_FULL, 0));
    dir.push_back(row(mk(som_pkg::REQ_CLEAR, 0, 0, 0, 0, 0), 1, 1, 0, som_pkg::ST_OK, 0));
    dir.push_back(row(mk(som_pkg::REQ_TICK, 0, 0, 0, 0, 0), 1, 1, 0, som_pkg::ST_OK, 1));

    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir[i])
      for (int k = 0; k < dir[i].reps; k++) offer(dir[i].r, dir[i].typed, dir[i].want);

    // random phases, each under a new channel count, written while the block is idle
    counts = '{4'd8, 4'd0, 4'd15, 4'd3, 4'd1, 4'd5, 4'd2};
    foreach (counts[p]) begin
      drain();
      write_mix_count(counts[p]);
      n = 0;
      while (n < RAND_PER_PHASE) begin
        burst = $urandom_range(1, 12);
        for (int k = 0; k < burst && n < RAND_PER_PHASE; k++) begin
          offer(rand_request(), 0, none_out);
          n++;
          // receiver holds off while requests keep coming
          if (p == 1 && n == 10) hold_req++;
        end
        if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 8));
      end
    end

    drain();
    $display("sent %0d requests (%0d ticks), checked %0d results", n_sent, n_ticks,
             n_checked);
    $display("%0d wraps and %0d full-list drops over %0d channel counts", n_wraps, n_full,
             counts.size());
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
